>>> rtl/efe_pkg.sv
package efe_pkg;

  // Line codes used by the framing.
  localparam logic [7:0] START_DELIM = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] XON_BYTE    = 8'h11;
  localparam logic [7:0] XOFF_BYTE   = 8'h13;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] SUM_BASE    = 8'hFF;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified input item: everything the back needs to emit its bytes.
  typedef struct packed {
    logic       hdr;      // first byte of a frame: delimiter and length go first
    logic [7:0] len_hi;
    logic [7:0] len_lo;
    logic [7:0] data;
    logic       has_chk;  // last byte of a frame: checksum follows
    logic [7:0] chk;
  } item_desc_t;

  // Status of the queue as seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // True for the byte values that must be escaped on the line.
  function automatic logic is_reserved(input logic [7:0] b);
    return (b == START_DELIM) || (b == ESC_BYTE) || (b == XON_BYTE) ||
           (b == XOFF_BYTE);
  endfunction

endpackage

>>> rtl/efe_if.sv
// Input channel: one payload byte and the frame length.
interface efe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] frame_length;

  modport source (output valid, output data_byte, output frame_length, input ready);
  modport sink (input valid, input data_byte, input frame_length, output ready);
endinterface

// Output channel: one encoded line byte per transaction.
interface efe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_end,
                output ready);
endinterface

>>> rtl/efe_front.sv
module efe_front (
  input  logic                 clk,
  input  logic                 rst,
  efe_in_if.sink               items,
  input  efe_pkg::queue_status_t q_status,
  output logic                 push,
  output efe_pkg::item_desc_t  push_desc
);

  logic        in_frame;
  logic [15:0] bytes_left;
  logic [7:0]  running_sum;

  logic [15:0] len_eff;
  logic [15:0] left_base;
  logic [15:0] left_next;
  logic [7:0]  sum_base;
  logic [7:0]  sum_next;
  logic        last;

  // Classify the incoming byte against the frame state.
  always_comb begin
    len_eff   = (items.frame_length == 16'd0) ? 16'd1 : items.frame_length;
    left_base = in_frame ? bytes_left : len_eff;
    sum_base  = in_frame ? running_sum : 8'd0;
    sum_next  = sum_base + items.data_byte;
    left_next = left_base - 16'd1;
    last      = (left_next == 16'd0);

    push_desc.hdr     = !in_frame;
    push_desc.len_hi  = len_eff[15:8];
    push_desc.len_lo  = len_eff[7:0];
    push_desc.data    = items.data_byte;
    push_desc.has_chk = last;
    push_desc.chk     = efe_pkg::SUM_BASE - sum_next;
  end

  assign items.ready = !q_status.full;
  assign push        = items.valid && !q_status.full;

  // Frame state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      bytes_left  <= 16'd0;
      running_sum <= 8'd0;
    end else if (push) begin
      if (last) begin
        in_frame    <= 1'b0;
        bytes_left  <= 16'd0;
        running_sum <= 8'd0;
      end else begin
        in_frame    <= 1'b1;
        bytes_left  <= left_next;
        running_sum <= sum_next;
      end
    end
  end

endmodule

>>> rtl/efe_queue.sv
module efe_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  efe_pkg::item_desc_t   push_desc,
  input  logic                  pop,
  output efe_pkg::item_desc_t   head,
  output efe_pkg::queue_status_t status
);

  efe_pkg::item_desc_t entries [efe_pkg::QUEUE_DEPTH];

  logic [efe_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [efe_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [efe_pkg::QUEUE_AW:0]   count;

  localparam logic [efe_pkg::QUEUE_AW:0] DEPTH_COUNT = (efe_pkg::QUEUE_AW + 1)'(
    efe_pkg::QUEUE_DEPTH);

  assign status.full  = (count == DEPTH_COUNT);
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  // Descriptor storage; needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/efe_back.sv
module efe_back (
  input  logic                   clk,
  input  logic                   rst,
  input  efe_pkg::item_desc_t    head,
  input  efe_pkg::queue_status_t q_status,
  output logic                   pop,
  efe_out_if.source              line
);

  typedef enum logic [2:0] {
    ST_DELIM,
    ST_HI,
    ST_LO,
    ST_DATA,
    ST_CHK
  } step_t;

  step_t      step;
  logic       active;
  logic       esc_pend;

  step_t      cur_step;
  step_t      step_after;
  logic [7:0] raw;
  logic [7:0] emit_byte;
  logic       tok_done;
  logic       item_done;
  logic       fire;

  // Pick the current token of the head item and work out its next line byte.
  always_comb begin
    if (active) begin
      cur_step = step;
    end else begin
      cur_step = head.hdr ? ST_DELIM : ST_DATA;
    end

    unique case (cur_step)
      ST_DELIM: begin
        raw        = efe_pkg::START_DELIM;
        step_after = ST_HI;
      end
      ST_HI: begin
        raw        = head.len_hi;
        step_after = ST_LO;
      end
      ST_LO: begin
        raw        = head.len_lo;
        step_after = ST_DATA;
      end
      ST_DATA: begin
        raw        = head.data;
        step_after = ST_CHK;
      end
      ST_CHK: begin
        raw        = head.chk;
        step_after = ST_CHK;
      end
      default: begin
        raw        = head.data;
        step_after = ST_CHK;
      end
    endcase

    // The delimiter goes out raw; every other reserved value takes two bytes.
    if (esc_pend) begin
      emit_byte = raw ^ efe_pkg::ESC_XOR;
      tok_done  = 1'b1;
    end else if ((cur_step != ST_DELIM) && efe_pkg::is_reserved(raw)) begin
      emit_byte = efe_pkg::ESC_BYTE;
      tok_done  = 1'b0;
    end else begin
      emit_byte = raw;
      tok_done  = 1'b1;
    end

    item_done = tok_done &&
                ((cur_step == ST_CHK) || ((cur_step == ST_DATA) && !head.has_chk));
  end

  assign fire = !q_status.empty && (!line.valid || line.ready);
  assign pop  = fire && item_done;

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_DELIM;
      active    <= 1'b0;
      esc_pend  <= 1'b0;
      line.valid <= 1'b0;
    end else begin
      if (fire) begin
        line.valid <= 1'b1;
      end else if (line.ready) begin
        line.valid <= 1'b0;
      end
      if (fire) begin
        line.out_byte  <= emit_byte;
        line.run_last  <= item_done;
        line.frame_end <= tok_done && (cur_step == ST_CHK);
        esc_pend       <= !tok_done;
        if (item_done) begin
          active <= 1'b0;
        end else begin
          active <= 1'b1;
          step   <= tok_done ? step_after : cur_step;
        end
      end
    end
  end

endmodule

>>> rtl/escaped_frame_encoder_core.sv
// Escaped frame encoder with an 8-bit checksum.
// The items channel takes one payload byte per transaction together with the
// frame length, which is sampled only on the first byte of a frame (a length
// of zero counts as one). The line channel gives one encoded byte per
// transaction: the start delimiter and the two length bytes before the first
// payload byte, the payload byte, and after the last byte the checksum
// 0xFF minus the byte sum. Reserved values are sent as the escape byte then
// the value XOR 0x20. run_last marks the last line byte of an input byte and
// frame_end the final byte of the checksum.
// Throughput is one line byte per cycle while the line receiver is ready,
// set by the back-end sequencer, so an input byte gives 1 to 9 line bytes,
// typically 1 or 2 mid-frame. A four-entry queue lets the front accept bytes
// while the back is still emitting. When the queue is empty, an accepted
// input byte is written into the queue and its first line byte then passes
// through the output register. Reset clears the frame state, the queue and
// the line valid flag. When the line receiver stalls, the output byte holds,
// the queue fills, and then items.ready drops until the queue has room again.
module escaped_frame_encoder_core (
  input  logic      clk,
  input  logic      rst,
  efe_in_if.sink    items,
  efe_out_if.source line
);

  efe_pkg::queue_status_t q_status;
  efe_pkg::item_desc_t    push_desc;
  efe_pkg::item_desc_t    head;
  logic                   push;
  logic                   pop;

  efe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .q_status  (q_status),
    .push      (push),
    .push_desc (push_desc)
  );

  efe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  efe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .line     (line)
  );

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 330;
  localparam int REPORT_LIMIT = 10;

  // One encoded byte as the line channel delivers it.
  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       frame_end;
  } line_byte_t;

  // Receiver readiness patterns.
  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_TOGGLE} stall_mode_t;

  // Tracks the framing state, predicts the line bytes of every accepted
  // payload byte and checks the line bytes in order.
  class frame_scoreboard;
    bit          open_frame;
    logic [15:0] remaining;
    logic [7:0]  byte_sum;
    line_byte_t  expected_line[$];
    int          mismatches;

    function bit must_escape(logic [7:0] b);
      return b == efe_pkg::START_DELIM || b == efe_pkg::ESC_BYTE ||
             b == efe_pkg::XON_BYTE || b == efe_pkg::XOFF_BYTE;
    endfunction

    // Queue one line byte, escaped when it is a reserved value.
    function void push_escaped(logic [7:0] b, logic end_flag);
      if (must_escape(b)) begin
        expected_line.push_back('{efe_pkg::ESC_BYTE, 1'b0, 1'b0});
        expected_line.push_back('{b ^ efe_pkg::ESC_XOR, 1'b0, end_flag});
      end else begin
        expected_line.push_back('{b, 1'b0, end_flag});
      end
    endfunction

    function void note_item(logic [7:0] data, logic [15:0] frame_len);
      logic [15:0] eff_len;
      line_byte_t  tail;
      // The first byte of a frame carries the delimiter and the length.
      if (!open_frame) begin
        eff_len = (frame_len == 16'd0) ? 16'd1 : frame_len;
        expected_line.push_back('{efe_pkg::START_DELIM, 1'b0, 1'b0});
        push_escaped(eff_len[15:8], 1'b0);
        push_escaped(eff_len[7:0], 1'b0);
        remaining  = eff_len;
        byte_sum   = 8'd0;
        open_frame = 1'b1;
      end
      push_escaped(data, 1'b0);
      byte_sum  = byte_sum + data;
      remaining = remaining - 16'd1;
      // The last byte of a frame is followed by the checksum.
      if (remaining == 16'd0) begin
        push_escaped(efe_pkg::SUM_BASE - byte_sum, 1'b1);
        open_frame = 1'b0;
        byte_sum   = 8'd0;
      end
      tail = expected_line.pop_back();
      tail.run_last = 1'b1;
      expected_line.push_back(tail);
    endfunction

    function void check_line(logic [7:0] value, logic run_last, logic frame_end);
      line_byte_t want;
      if (expected_line.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("line byte %02h run_last %0b frame_end %0b arrived with nothing expected",
                   value, run_last, frame_end);
      end else begin
        want = expected_line.pop_front();
        if (want.value !== value || want.run_last !== run_last ||
            want.frame_end !== frame_end) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("line byte wrong: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     want.value, want.run_last, want.frame_end,
                     value, run_last, frame_end);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   hold_req;
  bit   steady;
  int   burst_left;
  int   items_sent;
  int   cycle_count;

  frame_scoreboard sb = new;

  efe_in_if  items_if ();
  efe_out_if line_if ();

  escaped_frame_encoder_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .items (items_if),
    .line  (line_if)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Note every accepted payload transaction and check every line transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (items_if.valid && items_if.ready)
        sb.note_item(items_if.data_byte, items_if.frame_length);
      if (line_if.valid && line_if.ready)
        sb.check_line(line_if.out_byte, line_if.run_last, line_if.frame_end);
    end
  end

  // Line receiver: random stall patterns in segments, plus long hold-offs on request.
  initial begin
    int          seg_left;
    int          hold_left;
    stall_mode_t mode;
    seg_left     = 0;
    hold_left    = 0;
    mode         = RX_STEADY;
    line_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        line_if.ready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 60);
          mode     = stall_mode_t'($urandom_range(0, 3));
        end
        seg_left--;
        case (mode)
          RX_STEADY: begin
            line_if.ready = 1'b1;
          end
          RX_COIN: begin
            line_if.ready = 1'($urandom_range(0, 1));
          end
          RX_SPARSE: begin
            line_if.ready = ($urandom_range(0, 3) == 0);
          end
          default: begin
            line_if.ready = ~line_if.ready;
          end
        endcase
      end
    end
  end

  // Sender pacing: bursts of random length separated by random gaps unless steady is set.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if (!steady) begin
        gap = $urandom_range(1, 8);
        items_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Offer one payload byte and wait until the transaction completes.
  task automatic send_item(input logic [7:0] data, input logic [15:0] frame_len);
    items_if.valid        = 1'b1;
    items_if.data_byte    = data;
    items_if.frame_length = frame_len;
    do @(posedge clk); while (!items_if.ready);
    @(negedge clk);
    items_sent++;
    pace();
  endtask

  function automatic logic [7:0] reserved_value();
    case ($urandom_range(0, 3))
      0: return efe_pkg::START_DELIM;
      1: return efe_pkg::ESC_BYTE;
      2: return efe_pkg::XON_BYTE;
      default: return efe_pkg::XOFF_BYTE;
    endcase
  endfunction

  // Send a whole frame with random content; mid-frame lengths are junk and
  // must be ignored. Sometimes the last byte is chosen to make the checksum
  // a reserved value.
  task automatic send_frame(input logic [15:0] len_field);
    int         count;
    logic [7:0] sum;
    logic [7:0] data;
    count = (len_field == 16'd0) ? 1 : int'(len_field);
    sum   = 8'd0;
    for (int i = 0; i < count; i++) begin
      if (i == count - 1 && $urandom_range(0, 3) == 0)
        data = efe_pkg::SUM_BASE - sum - reserved_value();
      else if ($urandom_range(0, 7) == 0)
        data = reserved_value();
      else
        data = 8'($urandom_range(0, 255));
      send_item(data, (i == 0) ? len_field : 16'($urandom));
      sum = sum + data;
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [15:0] len_field;
    int          pick;
    int          frames;
    rst                   = 1'b1;
    items_if.valid        = 1'b0;
    items_if.data_byte    = 8'h00;
    items_if.frame_length = 16'h0000;
    hold_req              = 1'b0;
    steady                = 1'b0;
    burst_left            = 0;
    items_sent            = 0;
    cycle_count           = 0;
    frames                = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Zero length counts as one; the payload byte equals the delimiter.
    send_item(8'h7E, 16'h0000);
    // One-byte frames at the data extremes and with escaped checksums.
    send_item(8'hFF, 16'h0001);
    send_item(8'h00, 16'h0001);
    send_item(8'hEC, 16'h0001);
    send_item(8'h82, 16'h0001);
    send_item(8'hEE, 16'h0001);
    send_item(8'h81, 16'h0001);
    // Length on later bytes of a frame is ignored.
    send_item(8'h11, 16'h0002);
    send_item(8'h13, 16'hFFFF);
    send_item(8'h7D, 16'h0003);
    send_item(8'h7E, 16'h0000);
    send_item(8'hA5, 16'h5A5A);

    // Random frames, mostly short, some with escaped length bytes.
    hold_req = 1'b1;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        len_field = 16'd0;
      else if (pick < 12)
        len_field = ($urandom_range(0, 1) == 0) ? 16'h0011 : 16'h0013;
      else if (pick < 14)
        len_field = ($urandom_range(0, 1) == 0) ? 16'h007D : 16'h007E;
      else
        len_field = 16'($urandom_range(1, 8));
      steady = ($urandom_range(0, 7) == 0);
      frames++;
      if (frames == 25)
        hold_req = 1'b1;
      send_frame(len_field);
    end

    items_if.valid = 1'b0;
    while (sb.expected_line.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_line.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
